// File: design/rtfe_pkg.sv
// shared types, sizes and codes of the random time-shift feature expander
// no dependencies; imported by rtfe_copy_unit and the top level
`timescale 1ns / 1ps

package rtfe_pkg;

    // sizing
    localparam int MAX_SHIFT    = 15;
    localparam int MAX_FEATURES = 512;
    localparam int RING_DEPTH   = MAX_SHIFT + 1;
    localparam int SLOT_COUNT   = 16;
    localparam int RESULT_CAP   = 16;

    localparam int RING_W   = $clog2(RING_DEPTH);
    localparam int RING_W1  = RING_W + 1;
    localparam int FEAT_W   = $clog2(MAX_FEATURES);
    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W    = $clog2(RESULT_CAP + 1);
    localparam int HIST_AW  = RING_W + FEAT_W;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int TBL_AW   = SLOT_W + FEAT_W;
    localparam int TBL_DEPTH  = 1 << TBL_AW;

    // fixed field widths
    localparam int IDX_W  = 9;
    localparam int VAL_W  = 16;
    localparam int AMT_W  = 4;
    localparam int COL_W  = 13;
    localparam int FC_W   = 10;
    localparam int CP_W   = 5;
    localparam int FX_W   = 9;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 10;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // register reset values
    localparam logic [FC_W-1:0] FC_RESET = 10'd325;
    localparam logic [CP_W-1:0] CP_RESET = 5'd3;
    localparam logic [FX_W-1:0] FX_RESET = 9'd25;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_FEATURE_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_COPIES        = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_EXTRA         = 2'd2;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT_RD,
        ST_HIST_RD,
        ST_EMIT
    } state_t;

    // sequencer to copy unit
    typedef struct packed {
        logic init;
        logic advance;
    } copy_ctrl_t;

    // copy unit to sequencer
    typedef struct packed {
        logic [SLOT_W-1:0] k;
        logic [COL_W-1:0]  col;
        logic [RING_W-1:0] src;
        logic              last;
    } copy_stat_t;

endpackage

// File: design/rtfe_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module rtfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/rtfe_copy_unit.sv
// copy counter, column accumulator and ring index subtractor, shared by all copies
// depends on rtfe_pkg
`timescale 1ns / 1ps

module rtfe_copy_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rtfe_pkg::copy_ctrl_t          ctrl,
    input  logic [rtfe_pkg::IDX_W-1:0]    feat,
    input  logic [rtfe_pkg::FC_W-1:0]     fc_eff,
    input  logic [rtfe_pkg::CNT_W-1:0]    n,
    input  logic [rtfe_pkg::RING_W-1:0]   shift,
    input  logic [rtfe_pkg::RING_W-1:0]   step,
    output rtfe_pkg::copy_stat_t          stat
);
    import rtfe_pkg::*;

    logic [SLOT_W-1:0]  k_reg, k_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [RING_W1-1:0] wrap_sum;

    // copy number and column: column steps by the feature count
    always_comb begin
        k_next   = k_reg;
        col_next = col_reg;
        if (ctrl.init) begin
            k_next   = '0;
            col_next = COL_W'(feat);
        end else if (ctrl.advance) begin
            k_next   = k_reg + SLOT_W'(1);
            col_next = col_reg + COL_W'(fc_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else begin
            k_reg <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
    end

    // ring row that lies shift steps back
    assign wrap_sum = {1'b0, step} + RING_W1'(RING_DEPTH) - {1'b0, shift};

    always_comb begin
        stat.k    = k_reg;
        stat.col  = col_reg;
        stat.src  = (step >= shift) ? (step - shift) : wrap_sum[RING_W-1:0];
        stat.last = (({1'b0, k_reg} + CNT_W'(1)) == n);
    end

`ifndef SYNTHESIS
    // the counter only moves by one or restarts at zero
    a_k_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (k_reg != $past(k_reg)) |->
            (k_reg == '0) || (k_reg == $past(k_reg) + SLOT_W'(1)))
        else $error("copy counter jumped");
    // column restarts at the feature index
    a_col_init: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.init |=> col_reg == COL_W'($past(feat)))
        else $error("column did not start at the feature");
    // column advances with the count
    a_col_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance && !ctrl.init |=> col_reg == $past(col_reg) + COL_W'($past(fc_eff)))
        else $error("column did not advance by the feature count");
`endif

endmodule

// File: design/random_timeshift_feature_expander_top.sv
// top level of the random time-shift feature expander: sequencer, config, memories
// depends on rtfe_pkg, rtfe_ram, rtfe_copy_unit
`timescale 1ns / 1ps

// Usage
//   s_ channel: one beat is either a shift-table load (tuser = 1) or one
//   feature sample of the current step (tuser = 0). Loads and samples with an
//   index outside the feature count emit nothing.
//   m_ channel: a sample emits one beat per recalled copy, tlast on the final
//   copy. Each copy passes through three steps (shift-table read, history
//   read, output load) in the one copy unit; a sample recalls up to 16 copies.
//   The first copy is loaded after the decode, shift-table and history reads.
//   cfg channel: always ready; write only while the block is idle.
//   Reset: after aresetn the history ring is cleared one entry per cycle, all
//   8192 entries (s_tready low); config writes are taken meanwhile.
//   Stall: the output register holds its beat while m_tready is low and the
//   sequencer waits before loading the next copy; s_tready stays low until
//   the last copy of a sample has been loaded.
module random_timeshift_feature_expander_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // feature_index[8:0], sample_value[24:9], shift_slot[28:25],
    // shift_amount[32:29], zero pad[39:33]
    input  logic [rtfe_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[0]
    input  logic [0:0]                     s_tuser,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // column_index[12:0], feature_value[28:13], zero pad[31:29]
    output logic [rtfe_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtfe_pkg::CFG_AW-1:0]    cfg_index,
    input  logic [rtfe_pkg::CFG_DW-1:0]    cfg_data
);
    import rtfe_pkg::*;

    state_t state_reg, state_next;

    logic [FC_W-1:0] fc_reg;
    logic [CP_W-1:0] cp_reg;
    logic [FX_W-1:0] fx_reg;

    logic              cmd_reg;
    logic [IDX_W-1:0]  feat_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [AMT_W-1:0]  amt_reg;

    logic [RING_W-1:0]  step_reg, step_next;
    logic [HIST_AW-1:0] clr_reg, clr_next;

    logic               out_valid_reg, out_valid_next;
    logic [COL_W-1:0]   out_col_reg;
    logic [VAL_W-1:0]   out_val_reg;
    logic               out_last_reg;

    logic [FC_W-1:0]  fc_eff;
    logic [CP_W-1:0]  cp_sat;
    logic [CNT_W-1:0] n_copies;
    logic             in_range;
    logic             last_feat;
    logic             s_accept;
    logic             out_load;
    logic             step_adv;

    logic               tbl_we, tbl_re;
    logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
    logic [RING_W-1:0]  tbl_wdata, tbl_rdata;
    logic               hist_we, hist_re;
    logic [HIST_AW-1:0] hist_waddr, hist_raddr;
    logic [VAL_W-1:0]   hist_wdata, hist_rdata;

    copy_ctrl_t cctrl;
    copy_stat_t cstat;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg <= FC_RESET;
            cp_reg <= CP_RESET;
            fx_reg <= FX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FEATURE_COUNT: fc_reg <= cfg_data[FC_W-1:0];
                CFG_COPIES:        cp_reg <= cfg_data[CP_W-1:0];
                CFG_EXTRA:         fx_reg <= cfg_data[FX_W-1:0];
                default: ;
            endcase
        end
    end

    // effective feature count and copy count of the held sample
    always_comb begin
        if (fc_reg == '0) begin
            fc_eff = FC_W'(1);
        end else if (int'(fc_reg) > MAX_FEATURES) begin
            fc_eff = FC_W'(MAX_FEATURES);
        end else begin
            fc_eff = fc_reg;
        end
        cp_sat = (int'(cp_reg) > RESULT_CAP) ? CP_W'(RESULT_CAP) : cp_reg;
        n_copies = CNT_W'(cp_sat);
        if ((feat_reg < fx_reg) && (int'(cp_sat) < RESULT_CAP)) begin
            n_copies = CNT_W'(cp_sat) + CNT_W'(1);
        end
    end

    assign in_range  = ({1'b0, feat_reg} < fc_eff);
    assign last_feat = ({1'b0, feat_reg} == (fc_eff - FC_W'(1)));

    // input beat capture
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_tuser[0];
            feat_reg <= s_tdata[8:0];
            val_reg  <= s_tdata[24:9];
            slot_reg <= s_tdata[28:25];
            amt_reg  <= s_tdata[32:29];
        end
    end

    // output register
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_col_reg  <= cstat.col;
            out_val_reg  <= hist_rdata;
            out_last_reg <= cstat.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_val_reg, out_col_reg};
    assign m_tlast  = out_last_reg;

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            clr_reg   <= clr_next;
        end
    end

    // sequencer next state and memory controls
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        step_adv   = 1'b0;
        cctrl      = '0;
        tbl_we     = 1'b0;
        tbl_re     = 1'b0;
        hist_we    = 1'b0;
        hist_re    = 1'b0;
        hist_waddr = {step_reg, FEAT_W'(feat_reg)};
        hist_wdata = val_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = clr_reg;
                hist_wdata = '0;
                clr_next   = clr_reg + HIST_AW'(1);
                if (clr_reg == HIST_AW'(HIST_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                if (cmd_reg == CMD_LOAD) begin
                    tbl_we = (int'(feat_reg) < MAX_FEATURES);
                end else if (in_range) begin
                    hist_we = 1'b1;
                    if (n_copies == '0) begin
                        step_adv = last_feat;
                    end else begin
                        cctrl.init = 1'b1;
                        state_next = ST_SHIFT_RD;
                    end
                end
            end
            ST_SHIFT_RD: begin
                tbl_re     = 1'b1;
                state_next = ST_HIST_RD;
            end
            ST_HIST_RD: begin
                hist_re    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    if (cstat.last) begin
                        step_adv   = last_feat;
                        state_next = ST_IDLE;
                    end else begin
                        cctrl.advance = 1'b1;
                        state_next    = ST_SHIFT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ring row of the current step
    always_comb begin
        step_next = step_reg;
        if (step_adv) begin
            step_next = (step_reg == RING_W'(RING_DEPTH - 1)) ? '0 : step_reg + RING_W'(1);
        end
    end

    // table addressing, shift saturated on load
    assign tbl_waddr  = {slot_reg, FEAT_W'(feat_reg)};
    assign tbl_wdata  = (int'(amt_reg) > MAX_SHIFT) ? RING_W'(MAX_SHIFT) : RING_W'(amt_reg);
    assign tbl_raddr  = {cstat.k, FEAT_W'(feat_reg)};
    assign hist_raddr = {cstat.src, FEAT_W'(feat_reg)};

    rtfe_ram #(
        .WIDTH (RING_W),
        .DEPTH (TBL_DEPTH)
    ) u_shift_table (
        .clk     (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (tbl_re),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata)
    );

    rtfe_ram #(
        .WIDTH (VAL_W),
        .DEPTH (HIST_DEPTH)
    ) u_history (
        .clk     (aclk),
        .wr_en   (hist_we),
        .wr_addr (hist_waddr),
        .wr_data (hist_wdata),
        .rd_en   (hist_re),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    rtfe_copy_unit u_copy (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cctrl),
        .feat    (feat_reg),
        .fc_eff  (fc_eff),
        .n       (n_copies),
        .shift   (tbl_rdata),
        .step    (step_reg),
        .stat    (cstat)
    );

`ifndef SYNTHESIS
    // a new output beat only comes from the emit state
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("output beat raised outside emit");
    // the final copy returns the sequencer to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && cstat.last |=> state_reg == ST_IDLE)
        else $error("sequencer busy after final copy");
    // a copy read never runs past the copy count
    a_copy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT_RD) |-> ({1'b0, cstat.k} < n_copies))
        else $error("copy index beyond copy count");
    // the step moves only when a sample finishes
    a_step_move: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (step_reg != $past(step_reg)) |->
            $past(state_reg == ST_DECODE) || $past(state_reg == ST_EMIT))
        else $error("step advanced outside sample completion");
`endif

endmodule
